>>> hw/rtl/sorted_key_record_table_defines.svh
// Assertion macros shared by the checker.
`ifndef SORTED_KEY_RECORD_TABLE_DEFINES_SVH
`define SORTED_KEY_RECORD_TABLE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SKRT_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define SKRT_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hw/rtl/skrt_pkg.sv
package skrt_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      FUNC_SET    = 3'd0,
      FUNC_GET    = 3'd1,
      FUNC_REMOVE = 3'd2,
      FUNC_READ   = 3'd3,
      FUNC_CLEAR  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ARG   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [63:0] capsule;
      logic [63:0] last_time;
      logic [63:0] next_time;
      logic [63:0] period;
      logic [63:0] seed;
      logic [31:0] executed;
      logic [31:0] narrative;
      logic [63:0] compacted_time;
      logic [31:0] compactions;
   } record_type;

   typedef struct packed {
      logic [63:0] key;
      record_type  rec;
   } slot_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] key;
      logic [7:0]  position;
      logic [63:0] capsule_in;
      logic [63:0] last_time_in;
      logic [63:0] next_time_in;
      logic [63:0] period_in;
      logic [63:0] seed_in;
      logic [31:0] executed_in;
      logic [31:0] narrative_in;
      logic [63:0] compacted_time_in;
      logic [31:0] compactions_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] key_out;
      logic [63:0] capsule_out;
      logic [63:0] last_time_out;
      logic [63:0] next_time_out;
      logic [63:0] period_out;
      logic [63:0] seed_out;
      logic [31:0] executed_out;
      logic [31:0] narrative_out;
      logic [63:0] compacted_time_out;
      logic [31:0] compactions_out;
      logic [8:0]  entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CMP, S_SHIFT_RD,
      S_SHIFT_WR, S_WRITE, S_READ_WAIT, S_RESP
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;
      logic search_init;
      logic search_issue;
      logic search_step;
      logic up_init;
      logic down_init;
      logic shift_rd;
      logic shift_wr;
      logic write_new;
      logic pos_rd;
      logic cnt_inc;
      logic cnt_dec;
      logic cnt_clear;
      logic rsp_load;
      logic rsp_data;
      logic [1:0] rsp_status;
   } cmd_type;

   // Status back to controller.
   typedef struct packed {
      logic [2:0] func;
      logic key_zero;
      logic count_zero;
      logic full;
      logic pos_bad;
      logic search_open;
      logic hit;
      logic shift_done;
   } stat_type;

endpackage

>>> hw/rtl/skrt_datapath.sv
module skrt_datapath (
   input  logic              clock,
   input  logic              reset,
   input  skrt_pkg::req_type req_data,
   input  skrt_pkg::cmd_type cmd,
   output skrt_pkg::stat_type stat,
   output skrt_pkg::rsp_type rsp_data
);
   import skrt_pkg::*;

   slot_type mem [CAPACITY];
   slot_type rd_ff;

   req_type            req_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   lo_ff, hi_ff, lo_in, hi_in;
   logic [IDX_W-1:0]   mid_ff;
   logic               hit_ff, hit_in;
   logic [CNT_W-1:0]   sh_ff;
   logic [CNT_W-1:0]   sh_in;
   logic               up_ff;
   rsp_type            rsp_ff;
   logic [CNT_W-1:0]   mid_w;
   logic [IDX_W-1:0]   rd_addr;
   logic               rd_en;

   assign mid_w = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Read port: search probe, shift source or direct position.
   always_comb begin
      rd_en = 1'b0;
      rd_addr = mid_w[IDX_W-1:0];
      if (cmd.search_issue) begin
         rd_en = 1'b1;
      end else if (cmd.shift_rd) begin
         rd_en = 1'b1;
         rd_addr = up_ff ? IDX_W'(sh_ff - 1'b1) : IDX_W'(sh_ff + 1'b1);
      end else if (cmd.pos_rd) begin
         rd_en = 1'b1;
         rd_addr = req_ff.position[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= mem[rd_addr];
      if (cmd.shift_wr) mem[sh_ff[IDX_W-1:0]] <= rd_ff;
      else if (cmd.write_new) mem[lo_ff[IDX_W-1:0]] <= {req_ff.key, req_ff.capsule_in,
         req_ff.last_time_in, req_ff.next_time_in, req_ff.period_in, req_ff.seed_in,
         req_ff.executed_in, req_ff.narrative_in, req_ff.compacted_time_in,
         req_ff.compactions_in};
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      hit_in = hit_ff;
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = cnt_ff;
         hit_in = 1'b0;
      end else if (cmd.search_step) begin
         if (rd_ff.key == req_ff.key) begin
            hit_in = 1'b1;
            lo_in = CNT_W'(mid_ff);
            hi_in = CNT_W'(mid_ff);
         end else if (rd_ff.key < req_ff.key) begin
            lo_in = CNT_W'(mid_ff) + 1'b1;
         end else begin
            hi_in = CNT_W'(mid_ff);
         end
      end
      sh_in = sh_ff;
      if (cmd.up_init) sh_in = cnt_ff;
      else if (cmd.down_init) sh_in = lo_ff;
      else if (cmd.shift_wr) sh_in = up_ff ? sh_ff - 1'b1 : sh_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.search_issue) mid_ff <= mid_w[IDX_W-1:0];
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      hit_ff <= hit_in;
      sh_ff <= sh_in;
      if (cmd.up_init) up_ff <= 1'b1;
      else if (cmd.down_init) up_ff <= 1'b0;
      if (cmd.rsp_load) begin
         rsp_ff <= '0;
         rsp_ff.status <= cmd.rsp_status;
         if (cmd.rsp_data) begin
            rsp_ff.key_out <= rd_ff.key;
            rsp_ff.capsule_out <= rd_ff.rec.capsule;
            rsp_ff.last_time_out <= rd_ff.rec.last_time;
            rsp_ff.next_time_out <= rd_ff.rec.next_time;
            rsp_ff.period_out <= rd_ff.rec.period;
            rsp_ff.seed_out <= rd_ff.rec.seed;
            rsp_ff.executed_out <= rd_ff.rec.executed;
            rsp_ff.narrative_out <= rd_ff.rec.narrative;
            rsp_ff.compacted_time_out <= rd_ff.rec.compacted_time;
            rsp_ff.compactions_out <= rd_ff.rec.compactions;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_comb begin
      stat.func = req_ff.func;
      stat.key_zero = (req_ff.key == '0);
      stat.count_zero = (cnt_ff == '0);
      stat.full = (cnt_ff == CNT_W'(CAPACITY));
      stat.pos_bad = (CNT_W'(req_ff.position) >= cnt_ff) || (32'(req_ff.position) >= CAPACITY);
      stat.search_open = (lo_ff < hi_ff);
      stat.hit = hit_ff;
      // No copy is left once an up shift reaches the insert slot, or a down shift
      // reaches the already reduced count.
      stat.shift_done = up_ff ? (sh_ff == lo_ff) : (sh_ff >= cnt_ff);
   end

   // The count is final before the result is shown and holds while it waits.
   always_comb begin
      rsp_data = rsp_ff;
      rsp_data.entry_count = 9'(cnt_ff);
   end
endmodule

>>> hw/rtl/skrt_control.sv
module skrt_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  skrt_pkg::stat_type stat,
   output skrt_pkg::cmd_type  cmd
);
   import skrt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (stat.func) inside
               FUNC_SET, FUNC_GET:
                  state_in = stat.key_zero ? S_RESP : S_SRCH_RD;
               FUNC_REMOVE:
                  state_in = (stat.key_zero || stat.count_zero) ? S_RESP : S_SRCH_RD;
               FUNC_READ:   state_in = stat.pos_bad ? S_RESP : S_READ_WAIT;
               default:     state_in = S_RESP;
            endcase
         end
         S_SRCH_RD:   state_in = stat.search_open ? S_SRCH_WAIT : S_SRCH_CMP;
         S_SRCH_WAIT: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (stat.search_open) state_in = S_SRCH_RD;
            else if (stat.func == FUNC_SET && !stat.hit && !stat.full)
               state_in = S_SHIFT_RD;
            else if (stat.func == FUNC_REMOVE && stat.hit)
               state_in = S_SHIFT_RD;
            else if (stat.func == FUNC_SET && stat.hit) state_in = S_WRITE;
            else state_in = S_RESP;
         end
         S_SHIFT_RD:  state_in = stat.shift_done ? (stat.func == FUNC_SET ? S_WRITE : S_RESP)
                                                 : S_SHIFT_WR;
         S_SHIFT_WR:  state_in = S_SHIFT_RD;
         S_WRITE:     state_in = S_RESP;
         S_READ_WAIT: state_in = S_RESP;
         S_RESP:      if (!rsp_stall) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // The search loop: SRCH_RD issues a probe read when the range is open;
   // SRCH_CMP narrows the range with the registered key. When the range has
   // closed, SRCH_RD only falls through and CMP picks the finishing action.
   // SHIFT_RD checks for a remaining copy with the pointer already set up.
   always_comb begin
      cmd = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            cmd.search_init = 1'b1;
            cmd.rsp_load = 1'b1;
            cmd.rsp_status = ST_BAD_ARG;
            if (stat.func == FUNC_CLEAR) begin
               cmd.cnt_clear = 1'b1;
               cmd.rsp_status = ST_OK;
            end
            if (stat.func == FUNC_READ) cmd.pos_rd = !stat.pos_bad;
         end
         S_SRCH_RD:   cmd.search_issue = stat.search_open;
         S_SRCH_CMP: begin
            cmd.search_step = stat.search_open;
            if (!stat.search_open) begin
               if (stat.func == FUNC_SET && !stat.hit && !stat.full) cmd.up_init = 1'b1;
               if (stat.func == FUNC_REMOVE && stat.hit) begin
                  cmd.down_init = 1'b1;
                  cmd.cnt_dec = 1'b1;
               end
               cmd.rsp_load = 1'b1;
               cmd.rsp_status = stat.hit ? ST_OK
                              : (stat.func == FUNC_SET ? (stat.full ? ST_FULL : ST_OK)
                                                       : ST_NOT_FOUND);
               cmd.rsp_data = stat.hit && stat.func == FUNC_GET;
            end
         end
         S_SHIFT_RD:  cmd.shift_rd = !stat.shift_done;
         S_SHIFT_WR:  cmd.shift_wr = 1'b1;
         S_WRITE: begin
            cmd.write_new = 1'b1;
            cmd.cnt_inc = !stat.hit;
         end
         S_READ_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_status = ST_OK;
            cmd.rsp_data = 1'b1;
         end
         S_RESP:      ;
         default:     ;
      endcase
   end
endmodule

>>> hw/rtl/sorted_key_record_table.sv
// A get, set or remove first searches the sorted keys, with at most 9 probes. An
// insert then shifts each later entry up one slot before the write, and a remove
// shifts each later entry down one slot; a read at position needs no search.
// One word at a time: the next word is taken in the cycle after the result is accepted.
// Reset: synchronous, active high; the entry count clears, record storage is
// left as it is and is never read before being written.
module sorted_key_record_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  skrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output skrt_pkg::rsp_type rsp_data
);
   import skrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller steps the search, shift and write sequence. A remove drops
   // the entry count when its search ends with a hit, before the down shift starts.
   skrt_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .cmd(cmd)
   );

   skrt_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd),
      .stat(stat), .rsp_data(rsp_data)
   );
endmodule

>>> hw/rtl/skrt_checker.sv
module skrt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input skrt_pkg::rsp_type rsp_data
);
   `include "sorted_key_record_table_defines.svh"

   // While a result is pending no new word may be taken.
   `SKRT_ASSERT_IMP(a_busy, clock, reset, rsp_valid, req_stall, "input open with result pending")
   // A stalled result keeps its payload.
   `SKRT_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "result changed")
   // The entry count never exceeds the capacity.
   `SKRT_ASSERT_IMP(a_cnt, clock, reset, rsp_valid, rsp_data.entry_count <= 9'd256, "count too big")
endmodule

bind sorted_key_record_table skrt_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

>>> dv/sorted_key_record_table_test.sv
module sorted_key_record_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import skrt_pkg::*;

   // Clock and reset. Reset is held at the start and never again.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   always #5 clock = ~clock;

   sorted_key_record_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Shadow copy of the table, kept in key order, and the words the block owes us.
   slot_type shadow_slots[$];
   rsp_type  owed_rsps[$];
   int       error_count = 0;
   int       rsp_seen = 0;
   int       status_seen[4] = '{0, 0, 0, 0};
   bit       calm = 1'b0;

   // Directed rows: a request and, where it is obvious, the result typed in.
   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } row_type;

   function automatic rsp_type table_answer(input req_type rq);
      rsp_type  r;
      slot_type s;
      int       lo;
      int       hi;
      int       mid;
      bit       hit;
      r = '0;
      r.status = ST_BAD_ARG;
      lo = 0;
      hi = shadow_slots.size();
      hit = 1'b0;
      // Binary search of the shadow: lo ends at the hit or at the insertion point.
      while (lo < hi && !hit) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_slots[mid].key == rq.key) begin
            hit = 1'b1;
            lo = mid;
         end else if (shadow_slots[mid].key < rq.key) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      case (rq.func)
         FUNC_SET: begin
            if (rq.key != 0) begin
               s.key = rq.key;
               s.rec = '{rq.capsule_in, rq.last_time_in, rq.next_time_in, rq.period_in,
                         rq.seed_in, rq.executed_in, rq.narrative_in,
                         rq.compacted_time_in, rq.compactions_in};
               if (hit) begin
                  shadow_slots[lo] = s;
                  r.status = ST_OK;
               end else if (shadow_slots.size() >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  shadow_slots.insert(lo, s);
                  r.status = ST_OK;
               end
            end
         end
         FUNC_GET: begin
            if (rq.key != 0) begin
               if (hit) begin
                  s = shadow_slots[lo];
                  r.status = ST_OK;
               end else begin
                  r.status = ST_NOT_FOUND;
               end
            end
         end
         FUNC_REMOVE: begin
            if (rq.key != 0 && shadow_slots.size() != 0) begin
               if (hit) begin
                  shadow_slots.delete(lo);
                  r.status = ST_OK;
               end else begin
                  r.status = ST_NOT_FOUND;
               end
            end
         end
         FUNC_READ: begin
            if (rq.position < shadow_slots.size()) begin
               s = shadow_slots[rq.position];
               r.status = ST_OK;
               hit = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            shadow_slots.delete();
            r.status = ST_OK;
         end
         default: ;
      endcase
      // Only a successful get or read carries a record back.
      if (r.status == ST_OK && (rq.func == FUNC_GET || rq.func == FUNC_READ)) begin
         r.key_out = s.key;
         r.capsule_out = s.rec.capsule;
         r.last_time_out = s.rec.last_time;
         r.next_time_out = s.rec.next_time;
         r.period_out = s.rec.period;
         r.seed_out = s.rec.seed;
         r.executed_out = s.rec.executed;
         r.narrative_out = s.rec.narrative;
         r.compacted_time_out = s.rec.compacted_time;
         r.compactions_out = s.rec.compactions;
      end
      r.entry_count = 9'(shadow_slots.size());
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_type make_req(input logic [2:0] f, input logic [63:0] k,
                                        input logic [7:0] p);
      req_type rq;
      rq.func = f;
      rq.key = k;
      rq.position = p;
      rq.capsule_in = rand64();
      rq.last_time_in = rand64();
      rq.next_time_in = rand64();
      rq.period_in = rand64();
      rq.seed_in = rand64();
      rq.executed_in = $urandom();
      rq.narrative_in = $urandom();
      rq.compacted_time_in = rand64();
      rq.compactions_in = $urandom();
      return rq;
   endfunction

   // Picks a key: often one already stored, otherwise from a small pool so that
   // later requests hit it, and now and then a fully random or extreme value.
   function automatic logic [63:0] pick_key();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45 && shadow_slots.size() != 0) begin
         return shadow_slots[$urandom_range(0, shadow_slots.size() - 1)].key;
      end else if (sel < 85) begin
         return 64'($urandom_range(1, 400)) * 64'h0000_0100_0000_0001;
      end else if (sel < 90) begin
         return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      end else if (sel < 93) begin
         return '0;
      end
      return rand64();
   endfunction

   // Sends one word; valid stays up across back-to-back words, and drops only
   // for an idle burst. Everything moves on the falling edge.
   task automatic send_word(input req_type rq);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      owed_rsps.push_back(table_answer(rq));
      @(negedge clock);
   endtask

   // Result side: random stall bursts, and a field-by-field check on each word.
   initial begin
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (owed_rsps.size() == 0) begin
            $error("result word with nothing expected: %p", rsp_data);
            error_count++;
         end else begin
            e = owed_rsps.pop_front();
            status_seen[e.status]++;
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.key_out !== e.key_out) begin
               $error("key_out exp %h got %h", e.key_out, rsp_data.key_out);
               error_count++;
            end
            if (rsp_data.capsule_out !== e.capsule_out) begin
               $error("capsule_out exp %h got %h", e.capsule_out, rsp_data.capsule_out);
               error_count++;
            end
            if (rsp_data.last_time_out !== e.last_time_out) begin
               $error("last_time_out exp %h got %h", e.last_time_out, rsp_data.last_time_out);
               error_count++;
            end
            if (rsp_data.next_time_out !== e.next_time_out) begin
               $error("next_time_out exp %h got %h", e.next_time_out, rsp_data.next_time_out);
               error_count++;
            end
            if (rsp_data.period_out !== e.period_out) begin
               $error("period_out exp %h got %h", e.period_out, rsp_data.period_out);
               error_count++;
            end
            if (rsp_data.seed_out !== e.seed_out) begin
               $error("seed_out exp %h got %h", e.seed_out, rsp_data.seed_out);
               error_count++;
            end
            if (rsp_data.executed_out !== e.executed_out) begin
               $error("executed_out exp %h got %h", e.executed_out, rsp_data.executed_out);
               error_count++;
            end
            if (rsp_data.narrative_out !== e.narrative_out) begin
               $error("narrative_out exp %h got %h", e.narrative_out, rsp_data.narrative_out);
               error_count++;
            end
            if (rsp_data.compacted_time_out !== e.compacted_time_out) begin
               $error("compacted_time_out exp %h got %h", e.compacted_time_out,
                      rsp_data.compacted_time_out);
               error_count++;
            end
            if (rsp_data.compactions_out !== e.compactions_out) begin
               $error("compactions_out exp %h got %h", e.compactions_out,
                      rsp_data.compactions_out);
               error_count++;
            end
            if (rsp_data.entry_count !== e.entry_count) begin
               $error("entry_count exp %0d got %0d", e.entry_count, rsp_data.entry_count);
               error_count++;
            end
         end
      end
   end

   // Hard stop, far beyond what about 1600 words need even if each is a worst-case
   // insert or remove with idling on both channels.
   initial begin
      #100ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Main sequence.
   initial begin
      row_type rows[$];
      row_type rw;
      rsp_type want;
      int      i;
      int      sel;
      int      fills;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows on an empty table: the not-found and bad-argument codes can be read off directly.
      rw.fixed = 1'b1;
      rw.rsp = '0;
      rw.req = make_req(FUNC_GET, 64'd5, '0);
      rw.rsp.status = ST_NOT_FOUND;
      rows.push_back(rw);
      rw.req = make_req(FUNC_REMOVE, 64'd5, '0);
      rw.rsp.status = ST_BAD_ARG;             // remove on an empty table
      rows.push_back(rw);
      rw.req = make_req(FUNC_READ, '0, 8'd0);  // position at the count
      rows.push_back(rw);
      rw.req = make_req(FUNC_SET, '0, '0);     // key zero
      rows.push_back(rw);
      rw.req = make_req(3'd5, 64'd1, '0);      // unused function codes
      rows.push_back(rw);
      rw.req = make_req(3'd6, 64'd1, '0);
      rows.push_back(rw);
      rw.req = make_req(3'd7, 64'd1, 8'hFF);
      rows.push_back(rw);
      rw.req = make_req(FUNC_CLEAR, '0, '0);
      rw.rsp.status = ST_OK;
      rows.push_back(rw);
      // The rest use the predictor: extremes of key and data, overwrite, removal.
      rw.fixed = 1'b0;
      rw.req = make_req(FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      rw.req.capsule_in = '1;
      rw.req.executed_in = '1;
      rw.req.compactions_in = '1;
      rows.push_back(rw);
      rw.req = make_req(FUNC_SET, 64'd1, '0);
      rw.req.capsule_in = '0;
      rw.req.executed_in = '0;
      rows.push_back(rw);
      rw.req = make_req(FUNC_SET, 64'h8000_0000_0000_0000, '0);
      rows.push_back(rw);
      rw.req = make_req(FUNC_SET, 64'd1, '0);  // overwrite in place
      rows.push_back(rw);
      rw.req = make_req(FUNC_GET, 64'd1, '0);
      rows.push_back(rw);
      rw.req = make_req(FUNC_GET, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      rows.push_back(rw);
      rw.req = make_req(FUNC_READ, '0, 8'd0);
      rows.push_back(rw);
      rw.req = make_req(FUNC_READ, '0, 8'd2);
      rows.push_back(rw);
      rw.req = make_req(FUNC_READ, '0, 8'd3);
      rows.push_back(rw);
      rw.req = make_req(FUNC_GET, '0, '0);
      rows.push_back(rw);
      rw.req = make_req(FUNC_REMOVE, 64'd2, '0);
      rows.push_back(rw);
      rw.req = make_req(FUNC_REMOVE, 64'h8000_0000_0000_0000, '0);
      rows.push_back(rw);
      rw.req = make_req(FUNC_READ, '0, 8'd1);
      rows.push_back(rw);
      rw.req = make_req(FUNC_CLEAR, '0, '0);
      rows.push_back(rw);

      foreach (rows[i]) begin
         if (rows[i].fixed) begin
            want = table_answer(rows[i].req);
            if (want !== rows[i].rsp) begin
               $error("directed row %0d: table gives %p", i, want);
               error_count++;
            end
            // Undo nothing: error rows and clear leave the shadow empty either way.
         end
         send_word(rows[i].req);
      end

      // Random part. Two phases fill the table to capacity so that the full
      // status, the top read position and the longest shifts are reached.
      fills = 0;
      for (i = 0; i < 1100; i++) begin
         if (i >= 1000) calm = 1'b1;
         if ((i == 200 || i == 600) && fills < 2) begin
            fills++;
            while (shadow_slots.size() < CAPACITY)
               send_word(make_req(FUNC_SET, rand64() | 64'd1, '0));
            send_word(make_req(FUNC_SET, rand64() | 64'd1, '0));
            send_word(make_req(FUNC_READ, '0, 8'd255));
            send_word(make_req(FUNC_REMOVE, shadow_slots[0].key, '0));
            send_word(make_req(FUNC_SET, 64'd1, '0));
         end
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            send_word(make_req(FUNC_SET, pick_key(), '0));
         end else if (sel < 60) begin
            send_word(make_req(FUNC_GET, pick_key(), '0));
         end else if (sel < 78) begin
            send_word(make_req(FUNC_REMOVE, pick_key(), '0));
         end else if (sel < 94) begin
            send_word(make_req(FUNC_READ, '0,
                               $urandom_range(0, 3) == 0 ? 8'($urandom()) :
                               8'($urandom_range(0, shadow_slots.size() + 1))));
         end else if (sel < 97) begin
            send_word(make_req(3'($urandom_range(5, 7)), pick_key(), 8'($urandom())));
         end else begin
            send_word(make_req(FUNC_CLEAR, rand64(), 8'($urandom())));
         end
      end
      req_valid <= 1'b0;

      while (owed_rsps.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("Covered %0d result words: ok %0d, bad argument %0d, not found %0d, full %0d.",
               rsp_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("Table filled to capacity twice, with random idling on both channels.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/skrt_pkg.sv
hw/rtl/skrt_datapath.sv
hw/rtl/skrt_control.sv
hw/rtl/sorted_key_record_table.sv
hw/rtl/skrt_checker.sv
dv/sorted_key_record_table_test.sv
